// ----- rtl/next_lexicographic_permutation_top_assert.svh -----
// Assertion helpers for the permutation engine; clk and rst_n come from the using scope.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_ASSERT_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_ASSERT_SVH

// same-cycle implication
`define NLP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nlp: implication check failed");

// next-cycle implication
`define NLP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nlp: next-cycle check failed");

`endif

// ----- rtl/nlp_pkg.sv -----
`default_nettype none

package nlp_pkg;

    localparam int KEY_BITS = 50;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_EMIT    = 2'd2;

    typedef struct packed {
        logic [1:0]          command;
        logic [3:0]          index;
        logic [KEY_BITS-1:0] key;
    } req_t;

    typedef struct packed {
        logic [3:0]          position;
        logic [KEY_BITS-1:0] out_key;
        logic                advanced;
        logic                last;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/next_lexicographic_permutation_top.sv -----
// Permutation engine over up to MAX_ELEMENTS stored keys.
// Request channel (cmd_valid/cmd_ready, cmd_req): load writes one key and gives
// no result; emit reads out the first element_count keys; advance steps the
// keys to their next lexicographic permutation, then reads them out with
// advanced set, or leaves them alone with advanced clear if already last.
// Result channel (rsp_valid/rsp_ready, rsp): one result per position, last
// marks the final one. Results leave from a registered output stage.
// One request at a time: cmd_ready is high only while idle.
// Load writes its key from the idle state. Emit reads each key into the output
// register and holds it there until taken. Advance reads the last key, scans
// down for the pivot, probes for its successor, swaps the two, reverses the
// tail pair by pair and then emits. All of it is paced by the key store,
// which reads or writes one key at a time, and one shared key comparator.
// A stalled receiver holds the engine in place; nothing is dropped.
// Reset clears the sequencer and sets element_count to 2; the key store
// holds nothing until loaded. cfg_we writes element_count directly.
`default_nettype none

module next_lexicographic_permutation_top #(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_wdata,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire nlp_pkg::req_t cmd_req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output nlp_pkg::rsp_t      rsp
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    logic [4:0]                   element_count_reg;
    logic                         mem_wr_en;
    logic [AW-1:0]                mem_wr_addr;
    logic [nlp_pkg::KEY_BITS-1:0] mem_wr_data;
    logic                         mem_rd_en;
    logic [AW-1:0]                mem_rd_addr;
    logic [nlp_pkg::KEY_BITS-1:0] mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= 5'd2;
        end
        else if (cfg_we)
        begin
            element_count_reg <= cfg_wdata;
        end
    end

    nlp_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_count (element_count_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd_req       (cmd_req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    nlp_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

// ----- rtl/nlp_mem.sv -----
`default_nettype none

module nlp_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [nlp_pkg::KEY_BITS-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic [nlp_pkg::KEY_BITS-1:0]     rd_data
);

    logic [nlp_pkg::KEY_BITS-1:0] mem [DEPTH];
    logic [nlp_pkg::KEY_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/nlp_seq.sv -----
`default_nettype none
`include "next_lexicographic_permutation_top_assert.svh"

module nlp_seq #(
    parameter int MAX_ELEMENTS = 16,
    parameter int AW           = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [4:0]                   element_count,
    input  wire logic                         cmd_valid,
    output logic                              cmd_ready,
    input  wire nlp_pkg::req_t                cmd_req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output nlp_pkg::rsp_t                     rsp,
    output logic                              mem_wr_en,
    output logic [AW-1:0]                     mem_wr_addr,
    output logic [nlp_pkg::KEY_BITS-1:0]      mem_wr_data,
    output logic                              mem_rd_en,
    output logic [AW-1:0]                     mem_rd_addr,
    input  wire logic [nlp_pkg::KEY_BITS-1:0] mem_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_RD,
        S_INIT_CAP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SUCC_RD,
        S_SUCC_CMP,
        S_SWAP_B,
        S_REV_RDA,
        S_REV_RDB,
        S_REV_WA,
        S_REV_WB,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    state_t                       state_reg;
    logic [AW-1:0]                last_idx_reg;
    logic [AW-1:0]                p_reg;
    logic [AW-1:0]                piv_reg;
    logic [AW-1:0]                s_reg;
    logic [AW-1:0]                lo_reg;
    logic [AW-1:0]                hi_reg;
    logic [AW-1:0]                q_reg;
    logic [nlp_pkg::KEY_BITS-1:0] cur_key_reg;
    logic [nlp_pkg::KEY_BITS-1:0] piv_key_reg;
    logic [nlp_pkg::KEY_BITS-1:0] a_key_reg;
    logic                         adv_reg;
    logic                         rsp_valid_reg;
    nlp_pkg::rsp_t                rsp_reg;

    logic [AW-1:0]                last_idx_next;
    logic [nlp_pkg::KEY_BITS-1:0] cmp_a;
    logic [nlp_pkg::KEY_BITS-1:0] cmp_b;
    logic                         cmp_ge;
    logic                         index_ok;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign index_ok  = int'(cmd_req.index) < MAX_ELEMENTS;

    // active count minus one: zero counts as one, large counts saturate
    always_comb
    begin
        if (element_count == 5'd0)
        begin
            last_idx_next = '0;
        end
        else if (int'(element_count) > MAX_ELEMENTS)
        begin
            last_idx_next = AW'(MAX_ELEMENTS - 1);
        end
        else
        begin
            last_idx_next = AW'(element_count - 5'd1);
        end
    end

    // shared comparator and memory port steering
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        cmp_a       = mem_rd_data;
        cmp_b       = cur_key_reg;
        if (state_reg == S_SUCC_CMP)
        begin
            cmp_a = piv_key_reg;
            cmp_b = mem_rd_data;
        end
        cmp_ge = (cmp_a >= cmp_b);
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_req.command == nlp_pkg::CMD_LOAD && index_ok)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(cmd_req.index);
                    mem_wr_data = cmd_req.key;
                end
            end
            S_INIT_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = last_idx_reg;
            end
            S_SCAN_RD:
            begin
                if (p_reg != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = p_reg - 1'b1;
                end
            end
            S_SUCC_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = s_reg;
            end
            S_SUCC_CMP:
            begin
                if (!cmp_ge)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = piv_reg;
                    mem_wr_data = mem_rd_data;
                end
            end
            S_SWAP_B:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = s_reg;
                mem_wr_data = piv_key_reg;
            end
            S_REV_RDA:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = lo_reg;
                end
            end
            S_REV_RDB:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = hi_reg;
            end
            S_REV_WA:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = lo_reg;
                mem_wr_data = mem_rd_data;
            end
            S_REV_WB:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = hi_reg;
                mem_wr_data = a_key_reg;
            end
            S_EMIT_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = q_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        last_idx_reg <= last_idx_next;
                        adv_reg      <= 1'b0;
                        q_reg        <= '0;
                        unique case (cmd_req.command)
                            nlp_pkg::CMD_ADVANCE: state_reg <= S_INIT_RD;
                            nlp_pkg::CMD_EMIT:    state_reg <= S_EMIT_RD;
                            default:              state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_INIT_RD:
                begin
                    p_reg     <= last_idx_reg;
                    state_reg <= S_INIT_CAP;
                end
                S_INIT_CAP:
                begin
                    cur_key_reg <= mem_rd_data;
                    state_reg   <= S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    if (p_reg == '0)
                    begin
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CMP;
                    end
                end
                S_SCAN_CMP:
                begin
                    if (cmp_ge)
                    begin
                        cur_key_reg <= mem_rd_data;
                        p_reg       <= p_reg - 1'b1;
                        state_reg   <= S_SCAN_RD;
                    end
                    else
                    begin
                        piv_key_reg <= mem_rd_data;
                        piv_reg     <= p_reg - 1'b1;
                        s_reg       <= last_idx_reg;
                        state_reg   <= S_SUCC_RD;
                    end
                end
                S_SUCC_RD:
                begin
                    state_reg <= S_SUCC_CMP;
                end
                S_SUCC_CMP:
                begin
                    if (cmp_ge)
                    begin
                        s_reg     <= s_reg - 1'b1;
                        state_reg <= S_SUCC_RD;
                    end
                    else
                    begin
                        state_reg <= S_SWAP_B;
                    end
                end
                S_SWAP_B:
                begin
                    lo_reg    <= piv_reg + 1'b1;
                    hi_reg    <= last_idx_reg;
                    state_reg <= S_REV_RDA;
                end
                S_REV_RDA:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= S_REV_RDB;
                    end
                    else
                    begin
                        adv_reg   <= 1'b1;
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_REV_RDB:
                begin
                    a_key_reg <= mem_rd_data;
                    state_reg <= S_REV_WA;
                end
                S_REV_WA:
                begin
                    state_reg <= S_REV_WB;
                end
                S_REV_WB:
                begin
                    lo_reg    <= lo_reg + 1'b1;
                    hi_reg    <= hi_reg - 1'b1;
                    state_reg <= S_REV_RDA;
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    rsp_reg.position <= 4'(q_reg);
                    rsp_reg.out_key  <= mem_rd_data;
                    rsp_reg.advanced <= adv_reg;
                    rsp_reg.last     <= (q_reg == last_idx_reg);
                    rsp_valid_reg    <= 1'b1;
                    state_reg        <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT:
                begin
                    if (rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        if (q_reg == last_idx_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            q_reg     <= q_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `NLP_ASSERT_IMP(a_one_request, rsp_valid, !cmd_ready)
    `NLP_ASSERT_IMP(a_port_excl, mem_wr_en, !mem_rd_en)
    `NLP_ASSERT_IMP(a_rev_order, state_reg == S_REV_WB, lo_reg < hi_reg)
    `NLP_ASSERT_NXT(a_last_done, rsp_valid && rsp_ready && rsp.last, cmd_ready && !rsp_valid)

endmodule

`default_nettype wire
